@@ sv/lbbc_pkg.sv @@
// Shared types, constants and the PWM high-time function of the LED blink and breathe controller.
// Used by the controller top level; has no dependencies of its own.
package lbbc_pkg;

  localparam int NUM_LEDS = 3;
  localparam int LED_W = 2;
  localparam int PERIOD_W = 16;
  localparam int GAIN_W = 8;
  localparam int POWER_W = 7;
  localparam int COUNT_W = 8;
  localparam int PHASE_W = 16;
  localparam int INDEX_W = 9;
  localparam int TIME_W = 32;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 16;

  localparam logic [POWER_W-1:0] FULL_POWER = 7'd100;
  localparam logic [INDEX_W-1:0] PHASE_MAX = 9'd511;

  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 16'd1000;
  localparam logic [GAIN_W-1:0] GAIN0_RST = 8'd3;
  localparam logic [GAIN_W-1:0] GAIN1_RST = 8'd7;
  localparam logic [GAIN_W-1:0] GAIN2_RST = 8'd7;
  localparam logic [GAIN_W-1:0] RAMP_INTERVAL_RST = 8'd6;

  localparam logic [ADDR_W-1:0] REG_PWM_PERIOD = 3'd0;
  localparam logic [ADDR_W-1:0] REG_GAIN0 = 3'd1;
  localparam logic [ADDR_W-1:0] REG_GAIN1 = 3'd2;
  localparam logic [ADDR_W-1:0] REG_GAIN2 = 3'd3;
  localparam logic [ADDR_W-1:0] REG_RAMP_INTERVAL = 3'd4;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_POWER,
    CMD_BLINK,
    CMD_ANIM
  } cmd_t;

  // A lower high time is a brighter LED; the product saturates the result at zero.
  function automatic logic [PERIOD_W-1:0] drive_high(input logic [POWER_W-1:0] power,
                                                     input logic [GAIN_W-1:0] gain,
                                                     input logic [PERIOD_W-1:0] period);
    logic [POWER_W-1:0] sat;
    logic [POWER_W+GAIN_W-1:0] scaled;
    sat = (power > FULL_POWER) ? FULL_POWER : power;
    scaled = sat * gain;
    if ({1'b0, scaled} >= period) begin
      return '0;
    end
    return period - {1'b0, scaled};
  endfunction

endpackage

@@ sv/led_blink_breathe_controller.sv @@
// Top level of the LED blink and breathe controller: command decode, blink sequencers and ramp.
// Depends on lbbc_pkg.
//
// Each input beat carries one command: a millisecond tick, a power setting, a blink start or an
// animation switch for one LED. Every input beat produces exactly one output beat that shows
// the three PWM high times, the mask of blinking LEDs and the LED that owns the breathing ramp,
// all as they stand after that command.
// An accepted beat waits in an input register; when it fires, the state registers update and
// drive the output fields directly, and out_valid rises. One beat is taken per cycle while
// out_stall stays low.
// While out_stall holds a result, the state holds with it and the buffered beat waits, so
// in_stall rises once the input register is occupied.
// Configuration is written through cfg_en, cfg_addr and cfg_data at any edge and should only
// change while no beat is in flight. Writes to unknown indexes are ignored.
// Reset is synchronous: all LEDs are off at the reset period, blink and ramp state is cleared,
// the registers take their reset values and both valid flags drop.
module led_blink_breathe_controller
  import lbbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [LED_W-1:0]    led_sel,
  input  logic [POWER_W-1:0]  power_level,
  input  logic [COUNT_W-1:0]  blink_count,
  input  logic [PHASE_W-1:0]  blink_phase_len,
  input  logic                enable_flag,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PERIOD_W-1:0] high_time0,
  output logic [PERIOD_W-1:0] high_time1,
  output logic [PERIOD_W-1:0] high_time2,
  output logic [NUM_LEDS-1:0] blinking_mask,
  output logic [LED_W-1:0]    ramp_led,
  input  logic                cfg_en,
  input  logic [ADDR_W-1:0]   cfg_addr,
  input  logic [DATA_W-1:0]   cfg_data
);

  logic [PERIOD_W-1:0] pwm_period;
  logic [GAIN_W-1:0]   gain [NUM_LEDS];
  logic [GAIN_W-1:0]   ramp_interval;

  logic                item_valid;
  cmd_t                item_cmd;
  logic [LED_W-1:0]    item_led;
  logic [POWER_W-1:0]  item_power;
  logic [COUNT_W-1:0]  item_count;
  logic [PHASE_W-1:0]  item_plen;
  logic                item_enable;
  logic                fire;

  logic [TIME_W-1:0]   now_ticks, now_ticks_next;
  logic [TIME_W-1:0]   last_ramp_time, last_ramp_time_next;
  logic [PERIOD_W-1:0] duty_high [NUM_LEDS];
  logic [PERIOD_W-1:0] duty_high_next [NUM_LEDS];
  logic [NUM_LEDS-1:0] blink_active, blink_active_next;
  logic [NUM_LEDS-1:0] blink_lit, blink_lit_next;
  logic [NUM_LEDS-1:0] phase_odd, phase_odd_next;
  logic [NUM_LEDS-1:0] anim_enabled, anim_enabled_next;
  logic [COUNT_W-1:0]  flash_target [NUM_LEDS];
  logic [COUNT_W-1:0]  flash_target_next [NUM_LEDS];
  logic [PHASE_W-1:0]  phase_length [NUM_LEDS];
  logic [PHASE_W-1:0]  phase_length_next [NUM_LEDS];
  logic [PHASE_W-1:0]  phase_ticks [NUM_LEDS];
  logic [PHASE_W-1:0]  phase_ticks_next [NUM_LEDS];
  logic [INDEX_W-1:0]  phase_index [NUM_LEDS];
  logic [INDEX_W-1:0]  phase_index_next [NUM_LEDS];
  logic [LED_W-1:0]    anim_owner, anim_owner_next;
  logic [POWER_W-1:0]  ramp_level, ramp_level_next;
  logic                ramp_falling, ramp_falling_next;

  logic [PERIOD_W-1:0] full_high [NUM_LEDS];
  logic [PHASE_W-1:0]  tick_count [NUM_LEDS];
  logic [INDEX_W-1:0]  last_phase [NUM_LEDS];
  logic [TIME_W-1:0]   since_ramp;
  logic                led_ok;
  logic                ramp_due;
  logic [LED_W-1:0]    rot1, rot2;

  function automatic logic [LED_W-1:0] next_led(input logic [LED_W-1:0] led);
    return (led >= LED_W'(NUM_LEDS - 1)) ? '0 : led + 1'b1;
  endfunction

  assign fire = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !fire;

  assign high_time0 = duty_high[0];
  assign high_time1 = duty_high[1];
  assign high_time2 = duty_high[2];
  assign blinking_mask = blink_active;
  assign ramp_led = anim_owner;

  assign led_ok = item_led < LED_W'(NUM_LEDS);
  assign since_ramp = now_ticks + TIME_W'(1) - last_ramp_time;
  assign rot1 = next_led(anim_owner);
  assign rot2 = next_led(rot1);

  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      full_high[i] = drive_high(FULL_POWER, gain[i], pwm_period);
      tick_count[i] = phase_ticks[i] + 1'b1;
      last_phase[i] = {flash_target[i], 1'b0} - 1'b1;
    end
  end

  always_comb begin
    now_ticks_next = now_ticks;
    last_ramp_time_next = last_ramp_time;
    duty_high_next = duty_high;
    blink_active_next = blink_active;
    blink_lit_next = blink_lit;
    phase_odd_next = phase_odd;
    anim_enabled_next = anim_enabled;
    flash_target_next = flash_target;
    phase_length_next = phase_length;
    phase_ticks_next = phase_ticks;
    phase_index_next = phase_index;
    anim_owner_next = anim_owner;
    ramp_level_next = ramp_level;
    ramp_falling_next = ramp_falling;
    ramp_due = 1'b0;
    if (fire) begin
      unique case (item_cmd)
        CMD_TICK: begin
          now_ticks_next = now_ticks + 1'b1;
          for (int i = 0; i < NUM_LEDS; i++) begin
            if (blink_active[i]) begin
              if (tick_count[i] >= phase_length[i]) begin
                phase_ticks_next[i] = '0;
                if (phase_index[i] < PHASE_MAX) begin
                  phase_index_next[i] = phase_index[i] + 1'b1;
                end
                phase_odd_next[i] = !phase_odd[i];
              end else begin
                phase_ticks_next[i] = tick_count[i];
              end
              if (flash_target[i] != '0 && phase_index_next[i] >= last_phase[i]) begin
                duty_high_next[i] = pwm_period;
                blink_active_next[i] = 1'b0;
              end
              if (!phase_odd_next[i] && !blink_lit[i]) begin
                duty_high_next[i] = full_high[i];
                blink_lit_next[i] = 1'b1;
              end else if (phase_odd_next[i] && blink_lit[i]) begin
                duty_high_next[i] = pwm_period;
                blink_lit_next[i] = 1'b0;
              end
            end
          end
          ramp_due = (|anim_enabled) && (since_ramp > {{(TIME_W-GAIN_W){1'b0}}, ramp_interval})
                     && !blink_active_next[anim_owner];
          if (ramp_due) begin
            duty_high_next[anim_owner] = drive_high(ramp_level, gain[anim_owner], pwm_period);
            if (!ramp_falling) begin
              if (ramp_level >= FULL_POWER) begin
                ramp_level_next = FULL_POWER;
                ramp_falling_next = 1'b1;
              end else begin
                ramp_level_next = ramp_level + 1'b1;
              end
            end else if (ramp_level != '0) begin
              ramp_level_next = ramp_level - 1'b1;
            end else begin
              ramp_falling_next = 1'b0;
              for (int i = 0; i < NUM_LEDS; i++) begin
                duty_high_next[i] = pwm_period;
              end
              if (anim_enabled[rot1]) begin
                anim_owner_next = rot1;
              end else if (anim_enabled[rot2]) begin
                anim_owner_next = rot2;
              end
            end
            last_ramp_time_next = now_ticks_next;
          end
        end
        CMD_POWER: begin
          if (led_ok) begin
            duty_high_next[item_led] = drive_high(item_power, gain[item_led], pwm_period);
          end
        end
        CMD_BLINK: begin
          if (led_ok) begin
            blink_active_next[item_led] = 1'b1;
            blink_lit_next[item_led] = 1'b1;
            flash_target_next[item_led] = item_count;
            phase_length_next[item_led] = (item_plen == '0) ? PHASE_W'(1) : item_plen;
            phase_ticks_next[item_led] = '0;
            phase_index_next[item_led] = '0;
            phase_odd_next[item_led] = 1'b0;
            duty_high_next[item_led] = full_high[item_led];
          end
        end
        CMD_ANIM: begin
          if (led_ok) begin
            if (anim_enabled == '0) begin
              anim_owner_next = item_led;
              ramp_level_next = '0;
              ramp_falling_next = 1'b0;
            end
            anim_enabled_next[item_led] = item_enable;
            if (!item_enable) begin
              duty_high_next[item_led] = pwm_period;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= PWM_PERIOD_RST;
      gain[0] <= GAIN0_RST;
      gain[1] <= GAIN1_RST;
      gain[2] <= GAIN2_RST;
      ramp_interval <= RAMP_INTERVAL_RST;
    end else if (cfg_en) begin
      unique case (cfg_addr)
        REG_PWM_PERIOD:    pwm_period <= cfg_data[PERIOD_W-1:0];
        REG_GAIN0:         gain[0] <= cfg_data[GAIN_W-1:0];
        REG_GAIN1:         gain[1] <= cfg_data[GAIN_W-1:0];
        REG_GAIN2:         gain[2] <= cfg_data[GAIN_W-1:0];
        REG_RAMP_INTERVAL: ramp_interval <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_cmd <= cmd_t'(cmd);
      item_led <= led_sel;
      item_power <= power_level;
      item_count <= blink_count;
      item_plen <= blink_phase_len;
      item_enable <= enable_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid <= 1'b0;
      now_ticks <= '0;
      last_ramp_time <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        duty_high[i] <= PWM_PERIOD_RST;
        flash_target[i] <= '0;
        phase_length[i] <= '0;
        phase_ticks[i] <= '0;
        phase_index[i] <= '0;
      end
      blink_active <= '0;
      blink_lit <= '0;
      phase_odd <= '0;
      anim_enabled <= '0;
      anim_owner <= '0;
      ramp_level <= '0;
      ramp_falling <= 1'b0;
    end else begin
      item_valid <= in_valid || in_stall;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      now_ticks <= now_ticks_next;
      last_ramp_time <= last_ramp_time_next;
      duty_high <= duty_high_next;
      flash_target <= flash_target_next;
      phase_length <= phase_length_next;
      phase_ticks <= phase_ticks_next;
      phase_index <= phase_index_next;
      blink_active <= blink_active_next;
      blink_lit <= blink_lit_next;
      phase_odd <= phase_odd_next;
      anim_enabled <= anim_enabled_next;
      anim_owner <= anim_owner_next;
      ramp_level <= ramp_level_next;
      ramp_falling <= ramp_falling_next;
    end
  end

endmodule

@@ sv/lbbc_checker.sv @@
// Port-level checks for the LED blink and breathe controller, bound to its top level.
// Depends on lbbc_pkg and led_blink_breathe_controller.
module lbbc_checker
  import lbbc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [PERIOD_W-1:0] high_time0,
  input logic [PERIOD_W-1:0] high_time1,
  input logic [PERIOD_W-1:0] high_time2,
  input logic [NUM_LEDS-1:0] blinking_mask,
  input logic [LED_W-1:0]    ramp_led
);

  // Reset clears the result channel and the blink and ramp status.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && blinking_mask == '0 && ramp_led == '0)
    else $error("reset did not clear the result channel and status");

  // A held result keeps its beat and its fields.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(high_time0) && $stable(high_time1)
                               && $stable(high_time2) && $stable(blinking_mask))
    else $error("result changed while stalled");

  // With no result waiting, the input side can never be stalled.
  a_no_needless_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with the result channel empty");

  // No state moves unless a new result beat appears.
  a_quiet_when_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 !out_valid |-> $stable(high_time0) && $stable(high_time1)
                                  && $stable(high_time2) && $stable(ramp_led))
    else $error("outputs changed without a result beat");

  // The ramp owner is always a real LED.
  a_owner_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ramp_led != 2'd3)
    else $error("ramp owner out of range");

endmodule

bind led_blink_breathe_controller lbbc_checker u_lbbc_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .high_time0(high_time0),
  .high_time1(high_time1),
  .high_time2(high_time2),
  .blinking_mask(blinking_mask),
  .ramp_led(ramp_led)
);
